### sv/pmq_pkg.sv
// ----------------------------------------------------------------------------
// pmq_pkg
// shared types and codes of the priority mission queue
// ----------------------------------------------------------------------------
package pmq_pkg;

  localparam logic [2:0] NUM_TYPES = 3'd5;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_REQUEUE = 2'd1,
    CMD_CANCEL  = 2'd2,
    CMD_PEEK    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNSUPPORTED = 3'd1,
    ST_FULL        = 3'd2,
    ST_DROPPED     = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_EMPTY       = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_INS_HEAD,
    S_CAN_RD,
    S_CAN_CHK,
    S_SH_RD,
    S_SH_WR,
    S_PEEK_RD,
    S_PEEK_OUT
  } state_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic [31:0]        num;
    logic [2:0]         mtype;
    logic               tgt_valid;
    logic [15:0]        target_ref;
    logic [3:0]         attempts;
  } entry_t;

endpackage

### sv/pmq_if.sv
// ----------------------------------------------------------------------------
// pmq_in_if / pmq_out_if
// valid/ready channels for command and result words
// ----------------------------------------------------------------------------
interface pmq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] priority_req;
  logic [2:0]         job_type;
  logic               tgt_valid;
  logic [15:0]        target_ref;
  logic [3:0]         attempt_in;
  logic [31:0]        cancel_number;

  modport source (output valid, cmd, priority_req, job_type, tgt_valid,
                  target_ref, attempt_in, cancel_number, input ready);
  modport sink (input valid, cmd, priority_req, job_type, tgt_valid,
                target_ref, attempt_in, cancel_number, output ready);
endinterface

interface pmq_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [31:0]        mission_number;
  logic signed [15:0] head_priority;
  logic [2:0]         head_type;
  logic               head_tgt_valid;
  logic [15:0]        head_target_ref;
  logic [3:0]         head_attempts;
  logic [8:0]         queue_level;

  modport source (output valid, status, mission_number, head_priority, head_type,
                  head_tgt_valid, head_target_ref, head_attempts, queue_level,
                  input ready);
  modport sink (input valid, status, mission_number, head_priority, head_type,
                head_tgt_valid, head_target_ref, head_attempts, queue_level,
                output ready);
endinterface

### sv/priority_mission_queue.sv
// ----------------------------------------------------------------------------
// priority_mission_queue
// sorted pending-mission queue with requeue, cancel and peek
// ----------------------------------------------------------------------------
// a reject or an insert into an empty queue answers straight from idle; peek reads the head, then outputs it
// insert: reads and compares from the tail (S_INS_RD, S_INS_CHK), shifting entries toward the tail
// cancel: searches from the head (S_CAN_RD, S_CAN_CHK), then moves later entries up (S_SH_RD, S_SH_WR)
// one word in flight; next word accepted the cycle after the result is taken
// reset clears count and number counter and sets max_attempts to 3; store is unset
module priority_mission_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pmq_in_if.sink     in_ch,
  pmq_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);
  import pmq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   numctr_r, numctr_nxt;
  logic [3:0]    max_att_r;
  logic [AW-1:0] idx_r, idx_nxt;
  entry_t        new_r, new_nxt;
  logic [1:0]    cmd_r;
  logic [31:0]   cnum_r;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    o_status_r, o_status_nxt;
  logic [31:0]   o_num_r, o_num_nxt;
  entry_t        o_head_r, o_head_nxt;
  logic [CW-1:0] o_cnt_r, o_cnt_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  logic          acc;
  logic          in_bad_type, in_full, in_drop;
  logic [4:0]    att_next;
  logic [CW-1:0] idx_ext;
  logic          ins_stop, can_hit, more_after;

  pmq_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign acc         = in_ch.valid && in_ch.ready;
  assign att_next    = {1'b0, in_ch.attempt_in} + 5'd1;
  assign in_bad_type = in_ch.job_type >= NUM_TYPES;
  assign in_drop     = att_next >= {1'b0, max_att_r};
  assign in_full     = count_r >= FULL_CNT;
  assign idx_ext     = CW'(idx_r);
  assign ins_stop    = ram_rdata.prio >= new_r.prio;
  assign can_hit     = ram_rdata.num == cnum_r;
  assign more_after  = (idx_ext + CW'(1)) < count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (cmd_t'(in_ch.cmd))
            CMD_ENQUEUE, CMD_REQUEUE: begin
              if (!((in_ch.cmd == CMD_ENQUEUE) ? in_bad_type : in_drop) && !in_full &&
                  count_r != '0) begin
                state_nxt = S_INS_RD;
              end
            end
            CMD_CANCEL: if (count_r != '0) state_nxt = S_CAN_RD;
            CMD_PEEK:   if (count_r != '0) state_nxt = S_PEEK_RD;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_RD:   state_nxt = S_INS_CHK;
      S_INS_CHK:  begin
        if (ins_stop) state_nxt = S_IDLE;
        else if (idx_r == '0) state_nxt = S_INS_HEAD;
        else state_nxt = S_INS_RD;
      end
      S_INS_HEAD: state_nxt = S_IDLE;
      S_CAN_RD:   state_nxt = S_CAN_CHK;
      S_CAN_CHK:  begin
        if (can_hit) state_nxt = more_after ? S_SH_RD : S_IDLE;
        else state_nxt = more_after ? S_CAN_RD : S_IDLE;
      end
      S_SH_RD:    state_nxt = S_SH_WR;
      S_SH_WR:    state_nxt = ((idx_ext + CW'(2)) < count_r) ? S_SH_RD : S_IDLE;
      S_PEEK_RD:  state_nxt = S_PEEK_OUT;
      S_PEEK_OUT: state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    count_nxt     = count_r;
    numctr_nxt    = numctr_r;
    idx_nxt       = idx_r;
    new_nxt       = new_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_status_nxt  = o_status_r;
    o_num_nxt     = o_num_r;
    o_head_nxt    = o_head_r;
    o_cnt_nxt     = o_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = new_r;
    ram_raddr     = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          o_num_nxt  = '0;
          o_head_nxt = '0;
          o_cnt_nxt  = count_r;
          o_status_nxt = ST_OK;
          new_nxt.prio       = in_ch.priority_req;
          new_nxt.num        = numctr_r + 32'd1;
          new_nxt.mtype      = in_ch.job_type;
          new_nxt.tgt_valid  = in_ch.tgt_valid;
          new_nxt.target_ref = in_ch.target_ref;
          new_nxt.attempts   = (in_ch.cmd == CMD_REQUEUE) ? att_next[3:0] : 4'd0;
          idx_nxt = AW'(count_r - CW'(1));
          unique case (cmd_t'(in_ch.cmd))
            CMD_ENQUEUE, CMD_REQUEUE: begin
              if ((in_ch.cmd == CMD_ENQUEUE) ? in_bad_type : in_drop) begin
                o_status_nxt  = (in_ch.cmd == CMD_ENQUEUE) ? ST_UNSUPPORTED : ST_DROPPED;
                out_valid_nxt = 1'b1;
              end else if (in_full) begin
                o_status_nxt  = ST_FULL;
                out_valid_nxt = 1'b1;
              end else begin
                numctr_nxt = numctr_r + 32'd1;
                o_num_nxt  = numctr_r + 32'd1;
                if (count_r == '0) begin
                  ram_we        = 1'b1;
                  ram_waddr     = '0;
                  ram_wdata     = new_nxt;
                  count_nxt     = CW'(1);
                  o_cnt_nxt     = CW'(1);
                  out_valid_nxt = 1'b1;
                end
              end
            end
            CMD_CANCEL: begin
              idx_nxt = '0;
              if (count_r == '0) begin
                o_status_nxt  = ST_NOT_FOUND;
                out_valid_nxt = 1'b1;
              end
            end
            CMD_PEEK: begin
              if (count_r == '0) begin
                o_status_nxt  = ST_EMPTY;
                out_valid_nxt = 1'b1;
              end
            end
            default: o_status_nxt = ST_OK;
          endcase
        end
      end
      S_INS_CHK: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_ext + CW'(1));
        if (ins_stop) begin
          ram_wdata     = new_r;
          count_nxt     = count_r + CW'(1);
          o_cnt_nxt     = count_r + CW'(1);
          out_valid_nxt = 1'b1;
        end else begin
          ram_wdata = ram_rdata;
          if (idx_r != '0) idx_nxt = idx_r - AW'(1);
        end
      end
      S_INS_HEAD: begin
        ram_we        = 1'b1;
        ram_waddr     = '0;
        ram_wdata     = new_r;
        count_nxt     = count_r + CW'(1);
        o_cnt_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
      end
      S_CAN_CHK: begin
        if (can_hit) begin
          if (!more_after) begin
            count_nxt     = count_r - CW'(1);
            o_cnt_nxt     = count_r - CW'(1);
            out_valid_nxt = 1'b1;
          end
        end else if (more_after) begin
          idx_nxt = AW'(idx_ext + CW'(1));
        end else begin
          o_status_nxt  = ST_NOT_FOUND;
          out_valid_nxt = 1'b1;
        end
      end
      S_SH_RD: ram_raddr = AW'(idx_ext + CW'(1));
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        idx_nxt   = AW'(idx_ext + CW'(1));
        if (!((idx_ext + CW'(2)) < count_r)) begin
          count_nxt     = count_r - CW'(1);
          o_cnt_nxt     = count_r - CW'(1);
          out_valid_nxt = 1'b1;
        end
      end
      S_PEEK_RD: ram_raddr = '0;
      S_PEEK_OUT: begin
        o_head_nxt    = ram_rdata;
        o_num_nxt     = ram_rdata.num;
        out_valid_nxt = 1'b1;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      numctr_r    <= '0;
      max_att_r   <= 4'd3;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      numctr_r    <= numctr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) max_att_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    new_r      <= new_nxt;
    o_status_r <= o_status_nxt;
    o_num_r    <= o_num_nxt;
    o_head_r   <= o_head_nxt;
    o_cnt_r    <= o_cnt_nxt;
    if (acc) begin
      cmd_r  <= in_ch.cmd;
      cnum_r <= in_ch.cancel_number;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = o_status_r;
  assign out_ch.mission_number  = o_num_r;
  assign out_ch.head_priority   = (cmd_r == CMD_PEEK) ? o_head_r.prio : 16'sd0;
  assign out_ch.head_type       = o_head_r.mtype;
  assign out_ch.head_tgt_valid  = o_head_r.tgt_valid;
  assign out_ch.head_target_ref = o_head_r.target_ref;
  assign out_ch.head_attempts   = o_head_r.attempts;
  assign out_ch.queue_level     = 9'(o_cnt_r);

endmodule

### sv/pmq_ram.sv
// ----------------------------------------------------------------------------
// pmq_ram
// single write, single registered read entry store
// ----------------------------------------------------------------------------
module pmq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  pmq_pkg::entry_t   wdata,
  input  logic [AW-1:0]     raddr,
  output pmq_pkg::entry_t   rdata
);
  import pmq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
